// ===== rtl/yrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_pkg
// Shared types and constants of the yuv to rgb pixel format converter.
// ----------------------------------------------------------------------------
package yrc_pkg;

   // pixel format codes held in the format register
   localparam logic [1:0] FMT_BGRA   = 2'd0;
   localparam logic [1:0] FMT_NV12   = 2'd1;
   localparam logic [1:0] FMT_YCBYCR = 2'd2;
   localparam logic [1:0] FMT_CBYCRY = 2'd3;

   // depth of the job queue between front and back
   localparam int JOB_DEPTH = 2;
   localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // product and sum widths of the conversion datapath
   localparam int PROD_W = 18;
   localparam int SUM_W  = 20;

   // bt.601 integer coefficients
   localparam logic signed [PROD_W-1:0] COEF_Y  = 18'sd298;
   localparam logic signed [PROD_W-1:0] COEF_BD = 18'sd516;
   localparam logic signed [PROD_W-1:0] COEF_GD = 18'sd100;
   localparam logic signed [PROD_W-1:0] COEF_GE = 18'sd208;
   localparam logic signed [PROD_W-1:0] COEF_RE = 18'sd409;
   localparam logic signed [SUM_W-1:0]  ROUND   = 20'sd128;
   localparam logic signed [8:0]        LUMA_OFS = 9'sd16;

   // one request word
   typedef struct packed {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [7:0] byte_d;
      logic       second_pixel;
   } req_type;

   // one result pixel
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       last;
   } rsp_type;

   // classified job; in bgra mode luma0, luma1, chroma_b carry blue, green, red
   typedef struct packed {
      logic       is_rgb;
      logic       two;
      logic [7:0] luma0;
      logic [7:0] luma1;
      logic [7:0] chroma_b;
      logic [7:0] chroma_r;
   } job_type;

endpackage

// ===== rtl/yuv_rgb_pixel_format_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_rgb_pixel_format_converter
// Converts bgra or yuv words (nv12 pair, ycbycr, cbycry) into bgr pixels.
// ----------------------------------------------------------------------------
//  channel   ports                          moves
//  request   req_push / req_full / req_data one 4-byte word per push
//  response  rsp_pop / rsp_empty / rsp_data one bgr pixel per pop, last flag
//  csr       csr_wr_en / csr_wr_data        pixel format, written any cycle
//
// the back end makes one pixel per cycle unless a held response stalls it: a
// bgra word gives one pixel, a yuv word with two pixels gives two.
// a two-entry job queue lets the front accept while the back is busy.
// reset is synchronous and clears queues, pipeline valids and the format.
// a held response stalls the back stages, then the queue, then req_full.
// ----------------------------------------------------------------------------
module yuv_rgb_pixel_format_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  yrc_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   output yrc_pkg::rsp_type rsp_data,
   input  logic             rsp_pop,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);
   import yrc_pkg::*;

   logic [1:0] pixel_format_ff, pixel_format_in;
   logic       job_push, job_full, job_pop, job_empty;
   job_type    job_wr, job_rd;

   // format register
   assign pixel_format_in = csr_wr_en ? csr_wr_data : pixel_format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_BGRA;
      end else begin
         pixel_format_ff <= pixel_format_in;
      end
   end

   yrc_front u_front (
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .pixel_format (pixel_format_ff),
      .job_push     (job_push),
      .job_data     (job_wr),
      .job_full     (job_full)
   );

   yrc_job_fifo u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   yrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_rd),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

`ifndef SYNTH
   // the back never retires a job that is not queued
   assert property (@(posedge clock) disable iff (reset) job_pop |-> !job_empty)
      else $error("job popped from empty queue");

   // reset leaves no response pending and the request side open
   assert property (@(posedge clock) $past(reset) |-> rsp_empty && !req_full)
      else $error("state not cleared by reset");

   // a bgra job always ends its word on its single pixel
   assert property (@(posedge clock) disable iff (reset)
      u_back.issue && job_rd.is_rgb |-> job_pop)
      else $error("bgra job not retired on its single pixel");
`endif

endmodule

// ===== rtl/yrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_front
// Accepts request words and sorts their bytes into luma and chroma by format.
// ----------------------------------------------------------------------------
module yrc_front (
   input  logic             req_push,
   input  yrc_pkg::req_type req_data,
   output logic             req_full,
   input  logic [1:0]       pixel_format,
   output logic             job_push,
   output yrc_pkg::job_type job_data,
   input  logic             job_full
);
   import yrc_pkg::*;

   // handshake toward the job queue
   assign req_full = job_full;
   assign job_push = req_push && !job_full;

   // byte order per pixel format
   always_comb begin
      job_data.two = req_data.second_pixel;
      unique case (pixel_format)
         FMT_NV12: begin
            job_data.is_rgb   = 1'b0;
            job_data.luma0    = req_data.byte_a;
            job_data.luma1    = req_data.byte_b;
            job_data.chroma_b = req_data.byte_c;
            job_data.chroma_r = req_data.byte_d;
         end
         FMT_YCBYCR: begin
            job_data.is_rgb   = 1'b0;
            job_data.luma0    = req_data.byte_a;
            job_data.chroma_b = req_data.byte_b;
            job_data.luma1    = req_data.byte_c;
            job_data.chroma_r = req_data.byte_d;
         end
         FMT_CBYCRY: begin
            job_data.is_rgb   = 1'b0;
            job_data.chroma_b = req_data.byte_a;
            job_data.luma0    = req_data.byte_b;
            job_data.chroma_r = req_data.byte_c;
            job_data.luma1    = req_data.byte_d;
         end
         default: begin
            // bgra: alpha dropped, one pixel
            job_data.is_rgb   = 1'b1;
            job_data.luma0    = req_data.byte_a;
            job_data.luma1    = req_data.byte_b;
            job_data.chroma_b = req_data.byte_c;
            job_data.chroma_r = req_data.byte_d;
         end
      endcase
   end

endmodule

// ===== rtl/yrc_job_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_job_fifo
// Short register queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module yrc_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  yrc_pkg::job_type wr_data,
   output logic             full,
   input  logic             pop,
   output yrc_pkg::job_type rd_data,
   output logic             empty
);
   import yrc_pkg::*;

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/yrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_back
// Emits one pixel per cycle from queued jobs while the output is not held:
// product stage, then sum, round and clamp into the output register.
// ----------------------------------------------------------------------------
module yrc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  yrc_pkg::job_type job_data,
   output logic             job_pop,
   output logic             rsp_empty,
   output yrc_pkg::rsp_type rsp_data,
   input  logic             rsp_pop
);
   import yrc_pkg::*;

   // shift by 8 with floor and clamp to 0..255
   function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] shifted;
      shifted = sum >>> 8;
      if (sum[SUM_W-1]) begin
         clamp_byte = 8'd0;
      end else if (|shifted[SUM_W-1:8]) begin
         clamp_byte = 8'd255;
      end else begin
         clamp_byte = shifted[7:0];
      end
   endfunction

   logic                     phase_ff, phase_in;
   logic                     a_valid_ff, a_valid_in;
   logic                     a_is_rgb_ff;
   logic                     a_last_ff;
   logic [7:0]               a_blue_ff, a_green_ff, a_red_ff;
   logic signed [PROD_W-1:0] a_py_ff, a_pbd_ff, a_pgd_ff, a_pge_ff, a_pre_ff;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_data_ff, out_data_in;

   logic                     b_ready, a_ready, issue, pix_last;
   logic [7:0]               luma;
   logic signed [8:0]        c_val;
   logic signed [7:0]        d_val, e_val;
   logic signed [PROD_W-1:0] c_ext, d_ext, e_ext;
   logic signed [SUM_W-1:0]  sum_b, sum_g, sum_r;

   // stall chain and pixel sequencing
   always_comb begin
      b_ready    = !out_valid_ff || rsp_pop;
      a_ready    = !a_valid_ff || b_ready;
      issue      = !job_empty && a_ready;
      pix_last   = job_data.is_rgb || !job_data.two || phase_ff;
      job_pop    = issue && pix_last;
      phase_in   = issue ? !pix_last : phase_ff;
      a_valid_in = a_ready ? issue : a_valid_ff;
   end

   // offsets of luma and chroma
   always_comb begin
      luma  = phase_ff ? job_data.luma1 : job_data.luma0;
      c_val = $signed({1'b0, luma}) - LUMA_OFS;
      d_val = $signed({~job_data.chroma_b[7], job_data.chroma_b[6:0]});
      e_val = $signed({~job_data.chroma_r[7], job_data.chroma_r[6:0]});
      c_ext = PROD_W'(c_val);
      d_ext = PROD_W'(d_val);
      e_ext = PROD_W'(e_val);
   end

   // product stage
   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_is_rgb_ff <= job_data.is_rgb;
         a_last_ff   <= pix_last;
         a_blue_ff   <= job_data.luma0;
         a_green_ff  <= job_data.luma1;
         a_red_ff    <= job_data.chroma_b;
         a_py_ff     <= c_ext * COEF_Y;
         a_pbd_ff    <= d_ext * COEF_BD;
         a_pgd_ff    <= d_ext * COEF_GD;
         a_pge_ff    <= e_ext * COEF_GE;
         a_pre_ff    <= e_ext * COEF_RE;
      end
   end

   // sum, round and clamp
   always_comb begin
      sum_b = SUM_W'(a_py_ff) + SUM_W'(a_pbd_ff) + ROUND;
      sum_g = SUM_W'(a_py_ff) - SUM_W'(a_pgd_ff) - SUM_W'(a_pge_ff) + ROUND;
      sum_r = SUM_W'(a_py_ff) + SUM_W'(a_pre_ff) + ROUND;
      out_data_in.last = a_last_ff;
      if (a_is_rgb_ff) begin
         out_data_in.blue  = a_blue_ff;
         out_data_in.green = a_green_ff;
         out_data_in.red   = a_red_ff;
      end else begin
         out_data_in.blue  = clamp_byte(sum_b);
         out_data_in.green = clamp_byte(sum_g);
         out_data_in.red   = clamp_byte(sum_r);
      end
      out_valid_in = b_ready ? a_valid_ff : out_valid_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (b_ready) begin
         out_data_ff <= out_data_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the yuv to rgb pixel format converter. A driver
// pushes request words in random bursts and a monitor pops pixels with
// shifting stall patterns. Each accepted request is converted by a bt.601
// integer predictor into expected pixels, which are checked field by field
// against the popped results. The run walks all four pixel formats: a short
// directed set of corner values, then random phases.
// ----------------------------------------------------------------------------
module tb;
   import yrc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 12;

   typedef enum {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_PATTERN} pop_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   req_type    req_data = '0;
   logic       req_full;
   logic       rsp_empty;
   rsp_type    rsp_data;
   logic       rsp_pop = 1'b0;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = FMT_BGRA;

   // bench copy of the format register
   logic [1:0] cur_format = FMT_BGRA;

   req_type    pending_words[$];
   rsp_type    expected_pixels[$];
   int         mismatch_count = 0;
   int         idle_cycles = 0;

   yuv_rgb_pixel_format_converter uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data),
      .rsp_pop     (rsp_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // bt.601 conversion predictor
   // ------------------------------------------------------------------
   function automatic logic [7:0] clamp_byte(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   function automatic rsp_type bt601_pixel(logic [7:0] y, logic [7:0] cb,
                                           logic [7:0] cr, logic last);
      int      c;
      int      d;
      int      e;
      rsp_type px;
      c = int'(y) - 16;
      d = int'(cb) - 128;
      e = int'(cr) - 128;
      // arithmetic shift on signed int gives the floor
      px.blue  = clamp_byte((298 * c + 516 * d + 128) >>> 8);
      px.green = clamp_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
      px.red   = clamp_byte((298 * c + 409 * e + 128) >>> 8);
      px.last  = last;
      return px;
   endfunction

   function automatic void predict_pixels(req_type w, logic [1:0] fmt);
      logic [7:0] y0;
      logic [7:0] y1;
      logic [7:0] cb;
      logic [7:0] cr;
      rsp_type    px;
      // byte order per format; bgra passes straight through
      case (fmt)
         FMT_NV12: begin
            y0 = w.byte_a; y1 = w.byte_b; cb = w.byte_c; cr = w.byte_d;
         end
         FMT_YCBYCR: begin
            y0 = w.byte_a; cb = w.byte_b; y1 = w.byte_c; cr = w.byte_d;
         end
         FMT_CBYCRY: begin
            cb = w.byte_a; y0 = w.byte_b; cr = w.byte_c; y1 = w.byte_d;
         end
         default: begin
            px.blue  = w.byte_a;
            px.green = w.byte_b;
            px.red   = w.byte_c;
            px.last  = 1'b1;
            expected_pixels.push_back(px);
            return;
         end
      endcase
      // odd row end gives only the first luma pixel
      expected_pixels.push_back(bt601_pixel(y0, cb, cr, !w.second_pixel));
      if (w.second_pixel)
         expected_pixels.push_back(bt601_pixel(y1, cb, cr, 1'b1));
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic void add_word(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                    logic [7:0] d, logic two);
      req_type w;
      w.byte_a       = a;
      w.byte_b       = b;
      w.byte_c       = c;
      w.byte_d       = d;
      w.second_pixel = two;
      pending_words.push_back(w);
   endfunction

   // leans toward clamp and offset corners
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: begin
            case ($urandom_range(0, 3))
               0: return 8'd16;
               1: return 8'd128;
               2: return 8'd235;
               default: return 8'd240;
            endcase
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [1:0] format_by_index(int k);
      case (k % 4)
         0: return FMT_CBYCRY;
         1: return FMT_NV12;
         2: return FMT_BGRA;
         default: return FMT_YCBYCR;
      endcase
   endfunction

   function automatic bit work_outstanding();
      return pending_words.size() != 0 || req_push || expected_pixels.size() != 0;
   endfunction

   // wait until every request is out and every pixel is back, then write
   task automatic set_format(logic [1:0] fmt);
      @(negedge clock);
      while (reset || work_outstanding()) @(negedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      cur_format = fmt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      int n_words;

      // nv12 corners: full clamps, black and white, odd row ends
      set_format(FMT_NV12);
      add_word(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      add_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      add_word(8'd16, 8'd235, 8'd128, 8'd128, 1'b1);
      add_word(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
      add_word(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
      add_word(8'd81, 8'd145, 8'd90, 8'd240, 1'b0);
      add_word(8'd200, 8'd10, 8'd128, 8'd128, 1'b0);

      // bgra: alpha dropped, second pixel flag ignored
      set_format(FMT_BGRA);
      add_word(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      add_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      add_word(8'd1, 8'd2, 8'd3, 8'd170, 1'b1);
      add_word(8'd254, 8'd128, 8'd127, 8'd85, 1'b0);

      // packed 4:2:2 orders
      set_format(FMT_YCBYCR);
      add_word(8'd16, 8'd128, 8'd235, 8'd128, 1'b1);
      add_word(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
      add_word(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);

      set_format(FMT_CBYCRY);
      add_word(8'd128, 8'd16, 8'd128, 8'd235, 1'b1);
      add_word(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
      add_word(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);

      // random phases, each format first in turn, then any order
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_format(format_by_index(p < 4 ? p : $urandom_range(0, 3)));
         n_words = $urandom_range(60, 115);
         for (int i = 0; i < n_words; i++)
            add_word(random_byte(), random_byte(), random_byte(), random_byte(),
                     1'($urandom_range(0, 1)));
      end

      // drain, then give the block time to show any stray pixel
      @(negedge clock);
      while (work_outstanding()) @(negedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------
   // request driver: bursts of random length with random gaps
   // ------------------------------------------------------------------
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin
      logic    next_push;
      req_type next_data;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         next_push = req_push;
         next_data = req_data;
         if (req_push && !req_full) begin
            predict_pixels(req_data, cur_format);
            next_push = 1'b0;
         end
         if (!next_push) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() != 0) begin
               next_push = 1'b1;
               next_data = pending_words.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_push <= next_push;
         req_data <= next_data;
      end
   end

   // ------------------------------------------------------------------
   // pixel monitor and checker
   // ------------------------------------------------------------------
   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_pixel(rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: unexpected pixel, expected none, actual b=%0d g=%0d r=%0d last=%0d",
                  $time, got.blue, got.green, got.red, got.last);
         mismatch_count++;
      end else begin
         want = expected_pixels.pop_front();
         check_field("blue", want.blue, got.blue);
         check_field("green", want.green, got.green);
         check_field("red", want.red, got.red);
         check_field("last", want.last, got.last);
      end
   endtask

   pop_mode_type pop_mode    = POP_ALWAYS;
   int           mode_cycles = 40;
   logic [7:0]   pop_pattern = 8'hA5;

   // receiver stalls follow a mode that is redrawn when its random budget runs out
   always @(posedge clock) begin
      logic next_pop;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_pixel(rsp_data);
         mode_cycles--;
         if (mode_cycles <= 0) begin
            pop_mode    = pop_mode_type'($urandom_range(0, 3));
            mode_cycles = $urandom_range(20, 120);
            pop_pattern = 8'($urandom) | 8'h01;
         end
         case (pop_mode)
            POP_ALWAYS: next_pop = 1'b1;
            POP_HALF:   next_pop = 1'($urandom_range(0, 1));
            POP_SPARSE: next_pop = ($urandom_range(0, 3) == 0);
            default: begin
               next_pop    = pop_pattern[0];
               pop_pattern = {pop_pattern[0], pop_pattern[7:1]};
            end
         endcase
         rsp_pop <= next_pop;
      end
   end

   // ------------------------------------------------------------------
   // watchdog: no progress while work is outstanding
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || !work_outstanding())
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress, %0d pixels still expected",
                     $time, expected_pixels.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
